### hw/rtl/sorted_table_linear_interpolator_top_assert.svh
// Assertion macros for the sorted table interpolator
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define STLI_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define STLI_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define STLI_ASSERT_IMPL(label, clk, rst_n, a, c)
`define STLI_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/stli_pkg.sv
// Shared types and constants for the sorted table interpolator
package stli_pkg;
  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    WHERE_INTERP = 2'd0,
    WHERE_FIRST  = 2'd1,
    WHERE_LAST   = 2'd2,
    WHERE_EMPTY  = 2'd3
  } where_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [DataW-1:0]  time_value;
    logic [DataW-1:0]  in_x;
    logic [DataW-1:0]  in_y;
    logic [DataW-1:0]  in_aux;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0]  out_x;
    logic [DataW-1:0]  out_y;
    logic [DataW-1:0]  out_aux;
    logic [1:0]        where_code;
  } out_item_t;

  // Divider control between top and divide unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

### hw/rtl/stli_if.sv
// Valid/ready channel interfaces for the sorted table interpolator
interface stli_in_if import stli_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stli_out_if import stli_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/stli_div.sv
// Restoring divider for the Q1.16 interpolation weight, one quotient bit per cycle
module stli_div import stli_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DataW-1:0] num,
  input  logic [DataW-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [16:0]      weight
);
  // Quotient of (num << 16) / den, saturated at 65536. Since num < den is not
  // guaranteed, saturation is decided first by comparing num against den.
  localparam int unsigned QBits = 17;
  logic [DataW:0]      rem_r, rem_nxt;
  logic [DataW-1:0]    den_r;
  logic [QBits-1:0]    quo_r, quo_nxt;
  logic [4:0]          cnt_r;
  logic                sat_r;
  logic                busy_r, done_r;
  logic [DataW:0]      trial;

  assign trial = {rem_r[DataW-1:0], 1'b0} - {1'b0, den_r};

  always_comb begin
    rem_nxt = {rem_r[DataW-1:0], 1'b0};
    quo_nxt = {quo_r[QBits-2:0], 1'b0};
    if (!trial[DataW] || rem_r[DataW-1]) begin
      rem_nxt = {rem_r[DataW-1:0], 1'b0} - {1'b0, den_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        // num >= den means weight >= 1.0: saturate
        sat_r  <= (num >= den);
        rem_r  <= {1'b0, num};
        den_r  <= den;
        quo_r  <= '0;
        cnt_r  <= 5'd16;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign weight = sat_r ? 17'h10000 : quo_r;
endmodule

### hw/rtl/sorted_table_linear_interpolator_top.sv
// Top level of the sorted table linear interpolator
//   channel  dir  signals                                   request
//   in       in   in_valid/in_ready, op,time_value,x,y,aux   clear/append/query
//   out      out  out_valid/out_ready, x,y,aux,where_code    query result
// Clear and append leave the block idle; the next request can follow at once.
// A query runs s <= floor(log2(count))+1 search steps (read, compare), then
// two bracket reads, a weight divide and three multiply/add pairs; clamped
// answers take one bracket read and no divide, and an empty table skips
// the search. Reset clears the entry count, state and output valid, not the
// table; a waiting result holds off the next request.
module sorted_table_linear_interpolator_top import stli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefaultDepth
) (
  input  logic clk,
  input  logic rst_n,
  stli_in_if.sink    in_ch,
  stli_out_if.source out_ch
);
  `include "sorted_table_linear_interpolator_top_assert.svh"

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCHW, S_RD0, S_RD1, S_RDW, S_DIV, S_DIVW, S_MUL, S_ADD,
    S_OUT
  } state_t;

  // Row: time, x, y, aux
  logic [4*DataW-1:0] mem [TABLE_DEPTH];
  logic [4*DataW-1:0] rd_r;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   lo_r, len_r, half;
  logic [DataW-1:0] q_r;
  logic [4*DataW-1:0] row0_r, row1_r;
  logic [1:0]      lane_r;
  logic            out_valid_r;
  out_item_t       out_r;
  logic            div_start;
  logic            div_busy, div_done;
  logic [16:0]     weight;
  logic [DataW:0]  diff_r;
  logic signed [DataW+18:0] prod_r;
  logic [DataW-1:0] res_r [3];
  logic             in_fire;

  assign half    = len_r >> 1;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !(out_valid_r && !out_ch.ready);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      S_SRCH: begin rd_en = 1'b1; rd_addr = AW'(lo_r + half); end
      S_RD0:  begin rd_en = 1'b1; rd_addr = AW'(lo_r - CW'(1)); end
      S_RD1:  begin rd_en = 1'b1; rd_addr = AW'(lo_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.data.op == OP_APPEND && count_r < DepthC)
      mem[AW'(count_r)] <= {in_ch.data.time_value, in_ch.data.in_x,
                            in_ch.data.in_y, in_ch.data.in_aux};
    if (rd_en) rd_r <= mem[rd_addr];
  end

  stli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(q_r - row0_r[4*DataW-1 -: DataW]),
    .den(row1_r[4*DataW-1 -: DataW] - row0_r[4*DataW-1 -: DataW]),
    .busy(div_busy), .done(div_done), .weight(weight)
  );
  assign div_start = (state_r == S_DIV);

  function automatic logic [DataW-1:0] lane_of(input logic [4*DataW-1:0] row,
                                               input logic [1:0] l);
    logic [DataW-1:0] v;
    unique case (l)
      2'd0: v = row[3*DataW-1 -: DataW];
      2'd1: v = row[2*DataW-1 -: DataW];
      default: v = row[DataW-1:0];
    endcase
    return v;
  endfunction

  // Signed difference of one value lane at full precision
  function automatic logic [DataW:0] diff_of(input logic [4*DataW-1:0] hi_row,
                                             input logic [4*DataW-1:0] lo_row,
                                             input logic [1:0] l);
    logic [DataW-1:0] a, b;
    a = lane_of(hi_row, l);
    b = lane_of(lo_row, l);
    return {a[DataW-1], a} - {b[DataW-1], b};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_OUT) || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          q_r <= in_ch.data.time_value;
          priority if (in_ch.data.op == OP_CLEAR) begin
            count_r <= '0;
          end else if (in_ch.data.op == OP_APPEND) begin
            if (count_r < DepthC) count_r <= count_r + CW'(1);
          end else if (in_ch.data.op == OP_QUERY) begin
            lo_r  <= '0;
            len_r <= count_r;
            if (count_r == '0) begin
              out_r       <= '{out_x: '0, out_y: '0, out_aux: '0,
                               where_code: WHERE_EMPTY};
              state_r     <= S_OUT;
            end else begin
              state_r <= S_SRCH;
            end
          end else begin
            // drop unused op code
          end
        end
        S_SRCH: begin
          if (len_r == '0) begin
            state_r <= (lo_r == '0 || lo_r >= count_r) ? S_RD1 : S_RD0;
            if (lo_r >= count_r) lo_r <= count_r - CW'(1);
            lane_r  <= (lo_r == '0) ? 2'd1 : ((lo_r >= count_r) ? 2'd2 : 2'd0);
          end else begin
            state_r <= S_SRCHW;
          end
        end
        S_SRCHW: begin
          if (rd_r[4*DataW-1 -: DataW] < q_r) begin
            lo_r  <= lo_r + half + CW'(1);
            len_r <= len_r - half - CW'(1);
          end else begin
            len_r <= half;
          end
          state_r <= S_SRCH;
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          row0_r  <= rd_r;
          state_r <= S_RDW;
        end
        S_RDW: begin
          row1_r <= rd_r;
          if (lane_r != 2'd0) begin
            out_r.out_x      <= rd_r[3*DataW-1 -: DataW];
            out_r.out_y      <= rd_r[2*DataW-1 -: DataW];
            out_r.out_aux    <= rd_r[DataW-1:0];
            out_r.where_code <= (lane_r == 2'd1) ? WHERE_FIRST : WHERE_LAST;
            state_r          <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          lane_r  <= 2'd0;
          state_r <= S_DIVW;
        end
        S_DIVW: if (div_done) begin
          diff_r  <= diff_of(row1_r, row0_r, 2'd0);
          state_r <= S_MUL;
        end
        S_MUL: begin
          // Zero weight when t1 <= t0
          prod_r  <= $signed(diff_r) * $signed({1'b0,
                     (row1_r[4*DataW-1 -: DataW] > row0_r[4*DataW-1 -: DataW])
                     ? weight : 17'd0});
          state_r <= S_ADD;
        end
        S_ADD: begin
          // Arithmetic shift floors toward minus infinity
          res_r[lane_r] <= lane_of(row0_r, lane_r) + DataW'(prod_r >>> 16);
          if (lane_r == 2'd2) begin
            state_r <= S_OUT;
            out_r.out_x      <= res_r[0];
            out_r.out_y      <= res_r[1];
            out_r.out_aux    <= lane_of(row0_r, 2'd2) + DataW'(prod_r >>> 16);
            out_r.where_code <= WHERE_INTERP;
          end else begin
            lane_r  <= lane_r + 2'd1;
            diff_r  <= diff_of(row1_r, row0_r, lane_r + 2'd1);
            state_r <= S_MUL;
          end
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  `STLI_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, count_r <= DepthC)
  `STLI_ASSERT_IMPL(a_div_idle, clk, rst_n, state_r == S_IDLE, !div_busy)
  `STLI_ASSERT_NEXT(a_hold, clk, rst_n, out_valid_r && !out_ch.ready,
                    out_valid_r && $stable(out_r))
endmodule
